[hw/rtl/can_bts_pkg.sv]
// shared types, constants and field packing for the can bit-timing search
package can_bts_pkg;

   localparam logic [31:0] CLOCK_RATE_RESET = 32'd12000000;
   localparam logic [3:0]  PRESCALER_MAX    = 4'd15;
   localparam logic [4:0]  QUANTA_M1_MAX    = 5'd31;
   localparam logic [4:0]  SEGS_MIN         = 5'd3;
   localparam logic [4:0]  SEGS_MAX         = 5'd17;
   localparam logic [4:0]  DIV_STEP_LAST    = 5'd31;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic search_init;
      logic search_step;
      logic finish;
      logic hit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rate_zero;
      logic div_last;
      logic match;
      logic search_last;
   } status_type;

   // quanta-1 in 4:0 (bit 5 zero), jump width in 7:6, seg1 in 11:8, seg2 in 14:12
   function automatic logic [14:0] pack_timing(input logic [4:0] quanta_m1,
                                               input logic [4:0] segs);
      logic [4:0] s;
      logic [3:0] seg1;
      logic [3:0] seg2;
      logic [1:0] sjw;
      s    = segs - SEGS_MIN;
      seg1 = {1'b0, s[3:1]};
      seg2 = s[3:0] - seg1;
      sjw  = (seg1 > 4'd3) ? 2'd3 : seg1[1:0];
      return {seg2[2:0], seg1, sjw, 1'b0, quanta_m1};
   endfunction

endpackage

[hw/rtl/can_bts_ctrl.sv]
// controller state machine for the bit-timing search
module can_bts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   input  can_bts_pkg::status_type status,
   output can_bts_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIV    = 2'd1;
   localparam logic [1:0] ST_INIT   = 2'd2;
   localparam logic [1:0] ST_SEARCH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       strobe_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               // zero bit rate answers at once without dividing
               if (status.rate_zero) begin
                  cmd.finish = 1'b1;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.search_init = 1'b1;
            state_in        = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (status.match) begin
               cmd.finish = 1'b1;
               cmd.hit    = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.search_last) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.finish;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

[hw/rtl/can_bts_dp.sv]
// datapath: clock rate register, restoring divider, search counters, result registers
module can_bts_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [31:0]             csr_write_data,
   input  logic [31:0]             req_bit_rate,
   input  can_bts_pkg::cmd_type    cmd,
   output can_bts_pkg::status_type status,
   output logic [3:0]              rsp_prescaler,
   output logic [14:0]             rsp_timing_word,
   output logic                    rsp_found
);

   logic [31:0] clock_rate_ff;
   logic [31:0] divisor_ff;
   logic [31:0] rem_ff;
   logic [31:0] rem_in;
   logic [31:0] quo_ff;
   logic [31:0] quo_in;
   logic [4:0]  div_cnt_ff;
   logic [31:0] cpb_ff;

   logic [3:0]  presc_ff;
   logic [3:0]  presc_in;
   logic [4:0]  quanta_m1_ff;
   logic [4:0]  quanta_m1_in;
   logic [4:0]  segs_ff;
   logic [4:0]  segs_in;
   logic [9:0]  qd_ff;
   logic [9:0]  qd_in;
   logic [13:0] prod_ff;
   logic [13:0] prod_in;

   logic [3:0]  out_presc_ff;
   logic [14:0] out_timing_ff;
   logic        out_found_ff;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   // one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[31]};
      diff   = trial - {1'b0, divisor_ff};
      fits   = (trial >= {1'b0, divisor_ff});
      rem_in = fits ? diff[31:0] : trial[31:0];
      quo_in = {quo_ff[30:0], fits};
   end

   // product segs * quanta * (prescaler + 1) kept up to date by additions
   always_comb begin
      logic [9:0] qd_next;
      logic [4:0] div_p2;
      qd_next      = qd_ff + {5'd0, {1'b0, presc_ff} + 5'd1};
      div_p2       = {1'b0, presc_ff} + 5'd2;
      presc_in     = presc_ff;
      quanta_m1_in = quanta_m1_ff;
      segs_in      = segs_ff;
      qd_in        = qd_ff;
      prod_in      = prod_ff;
      if (segs_ff != can_bts_pkg::SEGS_MAX) begin
         segs_in = segs_ff + 5'd1;
         prod_in = prod_ff + {4'd0, qd_ff};
      end else if (quanta_m1_ff != can_bts_pkg::QUANTA_M1_MAX) begin
         segs_in      = can_bts_pkg::SEGS_MIN;
         quanta_m1_in = quanta_m1_ff + 5'd1;
         qd_in        = qd_next;
         prod_in      = {3'd0, qd_next, 1'b0} + {4'd0, qd_next};
      end else begin
         segs_in      = can_bts_pkg::SEGS_MIN;
         quanta_m1_in = '0;
         presc_in     = presc_ff + 4'd1;
         qd_in        = {5'd0, div_p2};
         prod_in      = {8'd0, div_p2, 1'b0} + {9'd0, div_p2};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_rate_ff <= can_bts_pkg::CLOCK_RATE_RESET;
      end else if (csr_write_en) begin
         clock_rate_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         divisor_ff <= req_bit_rate;
         rem_ff     <= '0;
         quo_ff     <= clock_rate_ff;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end

      if (cmd.search_init) begin
         cpb_ff       <= quo_ff;
         presc_ff     <= '0;
         quanta_m1_ff <= '0;
         segs_ff      <= can_bts_pkg::SEGS_MIN;
         qd_ff        <= 10'd1;
         prod_ff      <= 14'd3;
      end else if (cmd.search_step) begin
         presc_ff     <= presc_in;
         quanta_m1_ff <= quanta_m1_in;
         segs_ff      <= segs_in;
         qd_ff        <= qd_in;
         prod_ff      <= prod_in;
      end

      if (cmd.finish) begin
         if (cmd.hit) begin
            out_presc_ff  <= presc_ff;
            out_timing_ff <= can_bts_pkg::pack_timing(quanta_m1_ff, segs_ff);
            out_found_ff  <= 1'b1;
         end else begin
            out_presc_ff  <= '0;
            out_timing_ff <= '0;
            out_found_ff  <= 1'b0;
         end
      end
   end

   assign status.rate_zero   = (req_bit_rate == 32'd0);
   assign status.div_last    = (div_cnt_ff == can_bts_pkg::DIV_STEP_LAST);
   assign status.match       = (cpb_ff == {18'd0, prod_ff});
   assign status.search_last = (presc_ff == can_bts_pkg::PRESCALER_MAX) &&
                               (quanta_m1_ff == can_bts_pkg::QUANTA_M1_MAX) &&
                               (segs_ff == can_bts_pkg::SEGS_MAX);

   assign rsp_prescaler   = out_presc_ff;
   assign rsp_timing_word = out_timing_ff;
   assign rsp_found       = out_found_ff;

endmodule

[hw/rtl/can_bit_timing_search_core.sv]
// top level of the can bit-timing search
//
//   channel   ports                                       handshake
//   request   req_bit_rate                                start high while busy low
//   response  rsp_prescaler, rsp_timing_word, rsp_found   rsp_strobe, one cycle
//   config    csr_write_data                              csr_write_en
//
// a zero bit rate answers in the cycle after the transaction is taken
// otherwise the divider works out all 32 quotient bits, a setup state follows, then one
// prescaler/quanta/segments combination is tested per cycle (up to 7680 in all)
// reset clears the controller and loads the clock rate with 12000000
// the receiver cannot stall; busy stays high until the result is strobed
module can_bit_timing_search_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_bit_rate,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_prescaler,
   output logic [14:0] rsp_timing_word,
   output logic        rsp_found
);

   can_bts_pkg::cmd_type    cmd;
   can_bts_pkg::status_type status;

   can_bts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .cmd        (cmd)
   );

   can_bts_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_bit_rate    (req_bit_rate),
      .cmd             (cmd),
      .status          (status),
      .rsp_prescaler   (rsp_prescaler),
      .rsp_timing_word (rsp_timing_word),
      .rsp_found       (rsp_found)
   );

endmodule

[hw/rtl/can_bts_chk.sv]
// port-level checker for the can bit-timing search, bound to the top level
module can_bts_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_bit_rate,
   input logic        rsp_strobe,
   input logic [3:0]  rsp_prescaler,
   input logic [14:0] rsp_timing_word,
   input logic        rsp_found
);

   // a result only appears once the engine is free again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while busy");

   // zero bit rate gives an immediate not-found transaction
   a_zero_rate: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_bit_rate == 32'd0)) |=> (rsp_strobe && !rsp_found))
      else $error("zero bit rate not answered as not found");

   a_nonzero_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_bit_rate != 32'd0)) |=> busy)
      else $error("search did not start");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> ((rsp_prescaler == 4'd0) && (rsp_timing_word == 15'd0)))
      else $error("not-found result carries nonzero fields");

   // end of a search always delivers its result
   a_end_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("search ended without result");

endmodule

bind can_bit_timing_search_core can_bts_chk u_can_bts_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_bit_rate    (req_bit_rate),
   .rsp_strobe      (rsp_strobe),
   .rsp_prescaler   (rsp_prescaler),
   .rsp_timing_word (rsp_timing_word),
   .rsp_found       (rsp_found)
);

[test/can_bit_timing_search_checker.sv]
// checker for the can bit-timing search: predicts every request and compares the responses
`timescale 1ns / 100ps

module can_bit_timing_search_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_bit_rate,
   input  logic        rsp_strobe,
   input  logic [3:0]  rsp_prescaler,
   input  logic [14:0] rsp_timing_word,
   input  logic        rsp_found,
   output int          n_pending,
   output int          n_errors,
   output int          n_matched,
   output int          n_unmatched
);

   typedef struct {
      logic [31:0] clock_rate;
      logic [31:0] bit_rate;
      logic [3:0]  prescaler;
      logic [14:0] timing_word;
      logic        found;
   } bit_timing_type;

   logic [31:0]    clock_hz;
   bit_timing_type timing_due[$];

   // first exact prescaler/quanta/segments split of the clocks per bit
   function automatic bit_timing_type solve_bit_timing(input logic [31:0] clk_hz,
                                                       input logic [31:0] rate);
      bit_timing_type res;
      logic [31:0]    per_bit;
      int             s;
      int             seg1;
      int             seg2;
      int             sjw;
      res.clock_rate  = clk_hz;
      res.bit_rate    = rate;
      res.prescaler   = '0;
      res.timing_word = '0;
      res.found       = 1'b0;
      if (rate == 32'd0) begin
         return res;
      end
      per_bit = clk_hz / rate;
      for (int d = 0; d <= int'(can_bts_pkg::PRESCALER_MAX); d++) begin
         for (int q = 1; q <= int'(can_bts_pkg::QUANTA_M1_MAX) + 1; q++) begin
            for (int g = int'(can_bts_pkg::SEGS_MIN);
                 g <= int'(can_bts_pkg::SEGS_MAX); g++) begin
               if (per_bit == 32'(g * q * (d + 1))) begin
                  s    = g - int'(can_bts_pkg::SEGS_MIN);
                  seg1 = s / 2;
                  seg2 = s - seg1;
                  sjw  = (seg1 > 3) ? 3 : seg1;
                  res.prescaler   = 4'(d);
                  res.timing_word = 15'(((q - 1) & 'h3F) | ((sjw & 'h3) << 6)
                                        | ((seg1 & 'hF) << 8) | ((seg2 & 'h7) << 12));
                  res.found       = 1'b1;
                  return res;
               end
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      bit_timing_type want;
      if (reset) begin
         clock_hz    <= can_bts_pkg::CLOCK_RATE_RESET;
         timing_due.delete();
         n_pending   <= 0;
         n_errors    <= 0;
         n_matched   <= 0;
         n_unmatched <= 0;
      end else begin
         if (rsp_strobe) begin
            if (timing_due.size() == 0) begin
               if (n_errors < 10) begin
                  $display("%0t: response with no request: pre %0d word %h found %b",
                           $time, rsp_prescaler, rsp_timing_word, rsp_found);
               end
               n_errors <= n_errors + 1;
            end else begin
               want = timing_due.pop_front();
               if (rsp_prescaler !== want.prescaler || rsp_timing_word !== want.timing_word
                   || rsp_found !== want.found) begin
                  if (n_errors < 10) begin
                     $display("%0t: mismatch clock %0d bit rate %0d:",
                              $time, want.clock_rate, want.bit_rate);
                     $display("   expected pre %0d word %h found %b, got pre %0d word %h found %b",
                              want.prescaler, want.timing_word, want.found,
                              rsp_prescaler, rsp_timing_word, rsp_found);
                  end
                  n_errors <= n_errors + 1;
               end
               if (want.found) begin
                  n_matched <= n_matched + 1;
               end else begin
                  n_unmatched <= n_unmatched + 1;
               end
            end
         end
         if (start && !busy) begin
            timing_due.push_back(solve_bit_timing(clock_hz, req_bit_rate));
         end
         if (csr_write_en) begin
            clock_hz <= csr_write_data;
         end
         n_pending <= timing_due.size();
      end
   end

endmodule

[test/tb_can_bit_timing_search_core.sv]
// testbench top for the can bit-timing search: stimulus, clock settings and verdict
`timescale 1ns / 100ps

module tb_can_bit_timing_search_core;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_write_en   = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        start          = 1'b0;
   logic [31:0] req_bit_rate   = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [3:0]  rsp_prescaler;
   logic [14:0] rsp_timing_word;
   logic        rsp_found;

   int n_pending;
   int n_errors;
   int n_matched;
   int n_unmatched;
   int n_requests = 0;
   int n_settings = 0;
   bit pacing     = 1'b1;

   always #5 clock = ~clock;

   can_bit_timing_search_core u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .start           (start),
      .busy            (busy),
      .req_bit_rate    (req_bit_rate),
      .rsp_strobe      (rsp_strobe),
      .rsp_prescaler   (rsp_prescaler),
      .rsp_timing_word (rsp_timing_word),
      .rsp_found       (rsp_found)
   );

   can_bit_timing_search_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .start           (start),
      .busy            (busy),
      .req_bit_rate    (req_bit_rate),
      .rsp_strobe      (rsp_strobe),
      .rsp_prescaler   (rsp_prescaler),
      .rsp_timing_word (rsp_timing_word),
      .rsp_found       (rsp_found),
      .n_pending       (n_pending),
      .n_errors        (n_errors),
      .n_matched       (n_matched),
      .n_unmatched     (n_unmatched)
   );

   // called at a falling edge; returns at the falling edge after the transaction is taken
   task automatic request_timing(input logic [31:0] rate);
      if (pacing && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      start        <= 1'b1;
      req_bit_rate <= rate;
      while (busy) @(negedge clock);
      @(negedge clock);
      n_requests++;
   endtask

   // only written once the block is idle and every response is in
   task automatic set_clock_rate(input logic [31:0] hz);
      start <= 1'b0;
      @(negedge clock);
      while (n_pending != 0 || busy) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= hz;
      @(negedge clock);
      csr_write_en <= 1'b0;
      n_settings++;
   endtask

   // mostly rates derived from a random prescaler/quanta/segments split, the rest noise
   function automatic logic [31:0] pick_bit_rate(input logic [31:0] hz);
      int unsigned d;
      int unsigned q;
      int unsigned g;
      logic [31:0] rate;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0:       rate = $urandom;
            1:       rate = hz / $urandom_range(1, 9000);
            2:       rate = $urandom_range(1, 4000);
            default: rate = '0;
         endcase
      end else begin
         d    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
         q    = $urandom_range(1, 32);
         g    = $urandom_range(3, 17);
         rate = hz / ((d + 1) * q * g);
         if (rate == 0) begin
            rate = 32'd1;
         end
      end
      return rate;
   endfunction

   initial begin
      logic [31:0] hz;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset clock rate: zero rate, extremes, exact splits and a prime clocks-per-bit
      request_timing(32'd0);
      request_timing(32'd1);
      request_timing(32'hFFFF_FFFF);
      request_timing(32'h8000_0000);
      request_timing(32'd12000000);
      request_timing(32'd6000000);
      request_timing(32'd4000000);
      request_timing(32'd1000000);
      request_timing(32'd500000);
      request_timing(32'd125000);
      request_timing(32'd1465);

      // largest product: prescaler, quanta and segments all at their top
      set_clock_rate(32'd8704);
      request_timing(32'd1);
      request_timing(32'd2);
      request_timing(32'd8704);

      // zero clock rate never divides into a product
      set_clock_rate(32'd0);
      request_timing(32'd1);
      request_timing(32'd0);
      request_timing(32'hFFFF_FFFF);

      set_clock_rate(32'd1);
      request_timing(32'd1);
      request_timing(32'd0);

      set_clock_rate(32'hFFFF_FFFF);
      request_timing(32'd1);
      request_timing(32'h5555_5555);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       hz = 32'd16000000;
            1:       hz = 32'd48000000;
            2:       hz = $urandom_range(2000000, 32'hFFFF_FFFF);
            3:       hz = 32'd80000000;
            default: hz = 32'd24000000;
         endcase
         set_clock_rate(hz);
         pacing = (ph < 4);
         for (int i = 0; i < 20; i++) begin
            request_timing(pick_bit_rate(hz));
         end
      end

      start <= 1'b0;
      while (n_pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("run covered %0d bit-rate requests over %0d written clock rates plus the reset value",
               n_requests, n_settings);
      $display("%0d responses carried an exact timing split, %0d had none",
               n_matched, n_unmatched);
      if (n_errors == 0 && n_pending == 0) begin
         $display("can_bit_timing_search_core test passed");
      end else begin
         $display("can_bit_timing_search_core test failed");
      end
      $finish;
   end

   initial begin
      #50000000;
      $display("can_bit_timing_search_core test failed");
      $finish;
   end

endmodule
